// ===== hdl/apr_pkg.sv =====
// Shared types, constants and helper functions for the axis point rotator.
package apr_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_CORDIC_STEPS = 24;
    localparam int DEF_FRAC_BITS    = 16;

    // Datapath widths
    localparam int PH_W   = 32;              // phase, 2^32 = one full turn
    localparam int XY_W   = 34;              // CORDIC x/y, Q2.30 plus headroom
    localparam int Z_W    = 32;              // CORDIC residual phase
    localparam int COORD_W = 32;
    localparam int PROD_W = XY_W + COORD_W;  // coordinate times sine/cosine
    localparam int ACC_W  = PROD_W + 1;      // sum of two products

    // CORDIC start vector: gain compensation 0.60725 in Q2.30
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // 2^64 / (2*pi)
    localparam logic [63:0] RAD_SCALE = 64'd2935890503282001226;

    // Degree conversion: phase = floor((t * 2^(29-F) + 22) / 45)
    localparam int DEG_DIV      = 45;
    localparam int HALF_OFFSET  = 22;        // 360/16 rounded down
    localparam int POW32_MOD45  = 31;        // 2^32 mod 45

    // Axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Angle unit codes
    localparam logic KIND_DEG = 1'b0;
    localparam logic KIND_RAD = 1'b1;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Inverse of an odd number modulo 2^32 (Newton iteration, elaboration only)
    function automatic logic [31:0] inv_mod32(input logic [31:0] a);
        logic [31:0] x;
        x = a;
        for (int i = 0; i < 5; i++)
        begin
            x = x * (32'd2 - a * x);
        end
        return x;
    endfunction

    localparam logic [31:0] INV45 = inv_mod32(32'd45);

    // Residue modulo 45 of a narrow value: reciprocal multiply, one correction
    function automatic logic [5:0] mod45(input logic [13:0] v);
        logic [24:0] prod;
        logic [7:0]  q;
        logic [13:0] r;
        prod = 25'(v) * 25'd1456;
        q    = prod[23:16];
        r    = v - 14'(q) * 14'd45;
        if (r >= 14'd45)
        begin
            r = r - 14'd45;
        end
        return r[5:0];
    endfunction

    // atan(2^-k) in phase units
    function automatic logic signed [Z_W-1:0] atan_phase(input int k);
        logic signed [Z_W-1:0] a;
        case (k)
            0:       a = 32'sd536870912;
            1:       a = 32'sd316933406;
            2:       a = 32'sd167458907;
            3:       a = 32'sd85004756;
            4:       a = 32'sd42667331;
            5:       a = 32'sd21354465;
            6:       a = 32'sd10679838;
            7:       a = 32'sd5340245;
            8:       a = 32'sd2670163;
            9:       a = 32'sd1335087;
            10:      a = 32'sd667544;
            11:      a = 32'sd333772;
            12:      a = 32'sd166886;
            13:      a = 32'sd83443;
            14:      a = 32'sd41722;
            15:      a = 32'sd20861;
            16:      a = 32'sd10430;
            17:      a = 32'sd5215;
            18:      a = 32'sd2608;
            19:      a = 32'sd1304;
            20:      a = 32'sd652;
            21:      a = 32'sd326;
            22:      a = 32'sd163;
            23:      a = 32'sd81;
            24:      a = 32'sd41;
            25:      a = 32'sd20;
            26:      a = 32'sd10;
            27:      a = 32'sd5;
            28:      a = 32'sd3;
            29:      a = 32'sd1;
            30:      a = 32'sd1;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

    // Input transfer
    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [1:0]                axis;
        logic signed [COORD_W-1:0] turn;
    } point_t;

    // Output transfer
    typedef struct packed {
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
        logic signed [COORD_W-1:0] rz;
    } result_t;

    // Point and axis carried alongside the angle work
    typedef struct packed {
        logic [1:0]                axis;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
    } side_t;

    // Sideband through the CORDIC chain
    typedef struct packed {
        logic [1:0] quad;
        side_t      side;
    } carry_t;

    // CORDIC vector
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } vec_t;

endpackage

// ===== hdl/apr_phase.sv =====
// Angle to phase conversion, quadrant split and CORDIC start vector (5 stages).
module apr_phase #(
    parameter int FRAC_BITS = apr_pkg::DEF_FRAC_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  apr_pkg::point_t in_point,
    output logic            out_valid,
    output apr_pkg::vec_t   out_vec,
    output apr_pkg::carry_t out_carry
);
    import apr_pkg::*;

    // Degree path constants
    localparam int SHIFT   = 29 - FRAC_BITS;
    localparam int C45     = (1 << SHIFT) % DEG_DIV;
    localparam int NEG_ADJ = (DEG_DIV - (POW32_MOD45 * C45) % DEG_DIV) % DEG_DIV;

    // Radian path constants: rc split into two partial products
    localparam int RC_W   = 62 - FRAC_BITS;
    localparam int LO_W   = 27;
    localparam int HI_W   = RC_W - LO_W;
    localparam int PLO_W  = LO_W + 33;
    localparam int PHI_W  = HI_W + 33;
    localparam logic [63:0] RC =
        (RAD_SCALE + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    localparam logic [LO_W-1:0] RC_LO = RC[LO_W-1:0];
    localparam logic [HI_W-1:0] RC_HI = RC[RC_W-1:LO_W];

    logic [4:0] valid_reg;

    // Stage 1
    logic                     s1_kind_reg;
    side_t                    s1_side_reg;
    logic signed [31:0]       s1_t_reg;
    logic [13:0]              s1_fsum_reg;
    logic [13:0]              s1_fsum_next;
    logic signed [PLO_W-1:0]  s1_plo_reg;
    logic signed [PLO_W-1:0]  s1_plo_next;

    // Stage 2
    logic                     s2_kind_reg;
    side_t                    s2_side_reg;
    logic [10:0]              s2_w_reg;
    logic [10:0]              s2_w_next;
    logic [31:0]              s2_mlow_reg;
    logic [31:0]              s2_mlow_next;
    logic signed [PLO_W-1:0]  s2_plo_reg;
    logic signed [PHI_W-1:0]  s2_phi_reg;
    logic signed [PHI_W-1:0]  s2_phi_next;
    logic [5:0]               s2_um;

    // Stage 3
    logic                     s3_kind_reg;
    side_t                    s3_side_reg;
    logic [31:0]              s3_rphase_reg;
    logic [31:0]              s3_dnum_reg;
    logic [31:0]              s3_dnum_next;
    logic [63:0]              s3_rsum;

    // Stage 4
    side_t                    s4_side_reg;
    logic [PH_W-1:0]          s4_phase_reg;
    logic [PH_W-1:0]          s4_phase_next;
    logic [31:0]              s4_dphase;

    // Stage 5
    carry_t                   s5_carry_reg;
    logic signed [Z_W-1:0]    s5_z_reg;
    logic [PH_W-1:0]          s5_round;
    logic [1:0]               s5_quad;

    // Stage 1: fold the turn into 12-bit chunks (2^12 = 1 mod 45), low radian product
    always_comb
    begin
        s1_fsum_next = 14'(in_point.turn[11:0]) + 14'(in_point.turn[23:12])
                     + 14'(in_point.turn[31:24]);
        s1_plo_next  = PLO_W'(in_point.turn) * PLO_W'($signed({1'b0, RC_LO}));
    end

    // Stage 2: residue of the shifted turn, high radian product, low word of numerator
    always_comb
    begin
        s2_um        = mod45(s1_fsum_reg);
        s2_w_next    = 11'(s2_um) * 11'(C45) + 11'(HALF_OFFSET)
                     + (s1_t_reg[31] ? 11'(NEG_ADJ) : 11'd0);
        s2_phi_next  = PHI_W'(s1_t_reg) * PHI_W'($signed({1'b0, RC_HI}));
        s2_mlow_next = (s1_t_reg << SHIFT) + 32'(HALF_OFFSET);
    end

    // Stage 3: radian phase from the summed partials, exact-multiple numerator
    always_comb
    begin
        s3_rsum      = (64'(s2_phi_reg) << LO_W) + 64'(s2_plo_reg) + 64'h8000_0000;
        s3_dnum_next = s2_mlow_reg - 32'(mod45(14'(s2_w_reg)));
    end

    // Stage 4: exact division by 45 through its inverse modulo 2^32
    always_comb
    begin
        s4_dphase     = s3_dnum_reg * INV45;
        s4_phase_next = (s3_kind_reg == KIND_RAD) ? s3_rphase_reg : s4_dphase;
    end

    // Stage 5: nearest quadrant and residual phase
    always_comb
    begin
        s5_round = s4_phase_reg + 32'h2000_0000;
        s5_quad  = s5_round[31:30];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg      <= in_point.kind;
            s1_side_reg.axis <= in_point.axis;
            s1_side_reg.px   <= in_point.px;
            s1_side_reg.py   <= in_point.py;
            s1_side_reg.pz   <= in_point.pz;
            s1_t_reg         <= in_point.turn;
            s1_fsum_reg      <= s1_fsum_next;
            s1_plo_reg       <= s1_plo_next;

            s2_kind_reg      <= s1_kind_reg;
            s2_side_reg      <= s1_side_reg;
            s2_w_reg         <= s2_w_next;
            s2_mlow_reg      <= s2_mlow_next;
            s2_plo_reg       <= s1_plo_reg;
            s2_phi_reg       <= s2_phi_next;

            s3_kind_reg      <= s2_kind_reg;
            s3_side_reg      <= s2_side_reg;
            s3_rphase_reg    <= s3_rsum[63:32];
            s3_dnum_reg      <= s3_dnum_next;

            s4_side_reg      <= s3_side_reg;
            s4_phase_reg     <= s4_phase_next;

            s5_carry_reg.quad <= s5_quad;
            s5_carry_reg.side <= s4_side_reg;
            s5_z_reg          <= $signed(s4_phase_reg - {s5_quad, 30'd0});
        end
    end

    assign out_valid = valid_reg[4];
    assign out_carry = s5_carry_reg;
    assign out_vec   = '{x: CORDIC_GAIN, y: '0, z: s5_z_reg};

endmodule

// ===== hdl/apr_cordic_cell.sv =====
// One CORDIC rotation step with its sideband register.
module apr_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  apr_pkg::vec_t   in_vec,
    input  apr_pkg::carry_t in_carry,
    output logic            out_valid,
    output apr_pkg::vec_t   out_vec,
    output apr_pkg::carry_t out_carry
);
    import apr_pkg::*;

    localparam int K = STEP % 32;
    localparam logic signed [Z_W-1:0] ANGLE = atan_phase(K);

    logic                   valid_reg;
    vec_t                   vec_reg;
    vec_t                   vec_next;
    carry_t                 carry_reg;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    // Rotate toward zero residual phase
    always_comb
    begin
        xs = in_vec.x >>> K;
        ys = in_vec.y >>> K;
        if (!in_vec.z[Z_W-1])
        begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - ANGLE;
        end
        else
        begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg   <= vec_next;
            carry_reg <= in_carry;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_carry = carry_reg;

endmodule

// ===== hdl/apr_rotate.sv =====
// Quadrant fix-up, plane rotation, rounding and saturation (3 stages).
module apr_rotate (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  apr_pkg::vec_t    in_vec,
    input  apr_pkg::carry_t  in_carry,
    output logic             out_valid,
    output apr_pkg::result_t out_result
);
    import apr_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << 29;

    // Round-shifted sum at bit 30, clamped to 32-bit signed
    function automatic logic signed [31:0] sat_q30(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-31:0] sh;
        logic signed [31:0] r;
        sh = v[ACC_W-1:30];
        if ((&sh[ACC_W-31:31]) || !(|sh[ACC_W-31:31]))
        begin
            r = sh[31:0];
        end
        else if (sh[ACC_W-31])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    logic [2:0] valid_reg;

    // Stage 1
    logic signed [XY_W-1:0]    c_next;
    logic signed [XY_W-1:0]    s_next;
    logic signed [COORD_W-1:0] a_next;
    logic signed [COORD_W-1:0] b_next;
    logic signed [XY_W-1:0]    s1_c_reg;
    logic signed [XY_W-1:0]    s1_s_reg;
    logic signed [COORD_W-1:0] s1_a_reg;
    logic signed [COORD_W-1:0] s1_b_reg;
    side_t                     s1_side_reg;

    // Stage 2
    logic signed [PROD_W-1:0]  s2_ac_reg;
    logic signed [PROD_W-1:0]  s2_bs_reg;
    logic signed [PROD_W-1:0]  s2_as_reg;
    logic signed [PROD_W-1:0]  s2_bc_reg;
    side_t                     s2_side_reg;

    // Stage 3
    logic signed [ACC_W-1:0]   s3_u_reg;
    logic signed [ACC_W-1:0]   s3_v_reg;
    side_t                     s3_side_reg;

    logic signed [31:0]        ru;
    logic signed [31:0]        rv;

    // Map the first-quadrant vector to cosine and sine
    always_comb
    begin
        case (in_carry.quad)
            QUAD_0:
            begin
                c_next = in_vec.x;
                s_next = in_vec.y;
            end
            QUAD_1:
            begin
                c_next = -in_vec.y;
                s_next = in_vec.x;
            end
            QUAD_2:
            begin
                c_next = -in_vec.x;
                s_next = -in_vec.y;
            end
            default:
            begin
                c_next = in_vec.y;
                s_next = -in_vec.x;
            end
        endcase
    end

    // Pick the coordinate pair of the rotation plane
    always_comb
    begin
        case (in_carry.side.axis)
            AXIS_X:
            begin
                a_next = in_carry.side.py;
                b_next = in_carry.side.pz;
            end
            AXIS_Y:
            begin
                a_next = in_carry.side.pz;
                b_next = in_carry.side.px;
            end
            default:
            begin
                a_next = in_carry.side.px;
                b_next = in_carry.side.py;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_c_reg    <= c_next;
            s1_s_reg    <= s_next;
            s1_a_reg    <= a_next;
            s1_b_reg    <= b_next;
            s1_side_reg <= in_carry.side;

            s2_ac_reg   <= PROD_W'(s1_a_reg) * PROD_W'(s1_c_reg);
            s2_bs_reg   <= PROD_W'(s1_b_reg) * PROD_W'(s1_s_reg);
            s2_as_reg   <= PROD_W'(s1_a_reg) * PROD_W'(s1_s_reg);
            s2_bc_reg   <= PROD_W'(s1_b_reg) * PROD_W'(s1_c_reg);
            s2_side_reg <= s1_side_reg;

            s3_u_reg    <= ACC_W'(s2_ac_reg) - ACC_W'(s2_bs_reg) + ROUND;
            s3_v_reg    <= ACC_W'(s2_as_reg) + ACC_W'(s2_bc_reg) + ROUND;
            s3_side_reg <= s2_side_reg;
        end
    end

    // Route rotated pair back; axis code three passes the point through
    always_comb
    begin
        ru = sat_q30(s3_u_reg);
        rv = sat_q30(s3_v_reg);
        out_result.rx = s3_side_reg.px;
        out_result.ry = s3_side_reg.py;
        out_result.rz = s3_side_reg.pz;
        case (s3_side_reg.axis)
            AXIS_X:
            begin
                out_result.ry = ru;
                out_result.rz = rv;
            end
            AXIS_Y:
            begin
                out_result.rz = ru;
                out_result.rx = rv;
            end
            AXIS_Z:
            begin
                out_result.rx = ru;
                out_result.ry = rv;
            end
            default:
            begin
                out_result.rx = s3_side_reg.px;
            end
        endcase
    end

    assign out_valid = valid_reg[2];

endmodule

// ===== hdl/axis_point_rotator.sv =====
// Top level: rotates a 3D point about one coordinate axis through a CORDIC cell chain.
//
// Takes one point per clock and returns one rotated point per clock while the
// output is not stalled. The path from input transfer to result runs through
// angle-to-phase conversion (degrees are wrapped exactly to a full turn,
// radians go through a two-part constant multiply), one register per CORDIC
// cell, rotate, round and saturate, and the output register. All stages
// advance together; the input stalls only when the output register holds a
// result that has not been taken and the last stage of the chain is also
// full. Axis code three returns the point unchanged. Coordinates and angle
// are signed fixed point with FRAC_BITS fraction bits; results saturate to
// the 32-bit range.
module axis_point_rotator #(
    parameter int CORDIC_STEPS = apr_pkg::DEF_CORDIC_STEPS,
    parameter int FRAC_BITS    = apr_pkg::DEF_FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_ready,
    input  apr_pkg::point_t  point,
    output logic             result_valid,
    input  logic             result_ready,
    output apr_pkg::result_t result
);
    import apr_pkg::*;

    logic                  adv;
    logic [CORDIC_STEPS:0] chain_valid;
    vec_t                  chain_vec   [CORDIC_STEPS+1];
    carry_t                chain_carry [CORDIC_STEPS+1];
    logic                  last_valid;
    result_t               last_result;
    logic                  result_valid_reg;
    logic                  result_valid_next;
    result_t               result_reg;

    // Global advance: output free, being taken, or nothing arriving at it
    assign adv         = !result_valid_reg || result_ready || !last_valid;
    assign point_ready = adv;

    // Angle front end
    apr_phase #(
        .FRAC_BITS (FRAC_BITS)
    ) u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (point_valid),
        .in_point  (point),
        .out_valid (chain_valid[0]),
        .out_vec   (chain_vec[0]),
        .out_carry (chain_carry[0])
    );

    // CORDIC cell chain
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        apr_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_vec    (chain_vec[i]),
            .in_carry  (chain_carry[i]),
            .out_valid (chain_valid[i+1]),
            .out_vec   (chain_vec[i+1]),
            .out_carry (chain_carry[i+1])
        );
    end

    // Plane rotation back end
    apr_rotate u_rotate (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (chain_valid[CORDIC_STEPS]),
        .in_vec     (chain_vec[CORDIC_STEPS]),
        .in_carry   (chain_carry[CORDIC_STEPS]),
        .out_valid  (last_valid),
        .out_result (last_result)
    );

    // Output register
    assign result_valid_next = (last_valid && adv) || (result_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_valid && adv)
        begin
            result_reg <= last_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // An empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> point_ready)
        else $error("input stalled with an empty output register");

    // A stall freezes the end of the chain
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !point_ready |=> last_valid == $past(last_valid))
        else $error("pipeline moved during a stall");

    // A finished item leaving the chain lands in the output register
    a_item_lands: assert property (@(posedge clk) disable iff (!rst_n)
        last_valid && point_ready |=> result_valid)
        else $error("finished item lost at the output register");

endmodule

// ===== dv/axis_point_rotator_tb.sv =====
// Testbench for axis_point_rotator: directed table and random points checked against a predictor.
module axis_point_rotator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apr_pkg::*;

    localparam int  STEPS      = DEF_CORDIC_STEPS;
    localparam int  FRAC       = DEF_FRAC_BITS;
    localparam int  DEG        = 1 << FRAC;         // one degree or one radian
    localparam int  RAND_N     = 630;
    localparam int  CALM_N     = 80;                 // tail of the run without idling
    localparam int  DRAIN_TAIL = 64;                 // idle tail after the last expected result
    localparam int  CYCLE_CAP  = 200000;
    localparam longint FULL_DEG = longint'(360) << FRAC;
    localparam longint unsigned TURN_RATE = 64'd2935890503282001226;  // 2^64/(2*pi)
    localparam longint HALF_LSB = 64'sd536870912;    // rounding bit for Q2.30
    localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    typedef struct {
        point_t  pt;
        bit      has_exp;
        result_t exp;
    } row_t;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    point_valid  = 1'b0;
    logic    point_ready;
    point_t  point        = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // Typed-in expectation that travels with the point being offered
    bit      typed_has = 1'b0;
    result_t typed_res = '0;

    result_t rotated_q[$];
    row_t    dir_rows[$];
    int      fails       = 0;
    int      sent_n      = 0;
    int      checked_n   = 0;
    int      cycle_n     = 0;
    int      stall_odds  = 4;
    int      stall_left  = 0;

    axis_point_rotator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point        (point),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------- predictor ----------------

    // atan(2^-k) in phase units, 2^32 per turn
    function automatic longint atan_step(input int k);
        case (k)
            0:       return 536870912;
            1:       return 316933406;
            2:       return 167458907;
            3:       return 85004756;
            4:       return 42667331;
            5:       return 21354465;
            6:       return 10679838;
            7:       return 5340245;
            8:       return 2670163;
            9:       return 1335087;
            10:      return 667544;
            11:      return 333772;
            12:      return 166886;
            13:      return 83443;
            14:      return 41722;
            15:      return 20861;
            16:      return 10430;
            17:      return 5215;
            18:      return 2608;
            19:      return 1304;
            20:      return 652;
            21:      return 326;
            22:      return 163;
            23:      return 81;
            24:      return 41;
            25:      return 20;
            26:      return 10;
            27:      return 5;
            28:      return 3;
            29:      return 1;
            30:      return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return MAXV;
        if (v < -64'sd2147483648)
            return MINV;
        return v[31:0];
    endfunction

    // Angle to a 32-bit phase; wrap-around is the reduction modulo a turn
    function automatic logic [31:0] phase_of_angle(input logic kind, input logic signed [31:0] t);
        longint          tt;
        longint          r;
        longint unsigned n;
        longint unsigned rc;
        longint unsigned prod;
        tt = t;
        if (kind == KIND_DEG)
        begin
            r = tt % FULL_DEG;
            if (r < 0)
                r = r + FULL_DEG;
            n = $unsigned(r << (33 - FRAC)) + 64'd360;
            return 32'(n / 64'd720);
        end
        rc   = (TURN_RATE + (64'd1 << (FRAC - 1))) >> FRAC;
        prod = $unsigned(tt) * rc + 64'h80000000;
        return 32'(prod >> 32);
    endfunction

    // Quadrant fold, then the CORDIC iterations on the residual phase
    function automatic void cordic_sincos(input logic [31:0] phase,
                                          output longint c, output longint s);
        logic [31:0]        q;
        logic [31:0]        d;
        logic signed [31:0] zs;
        logic [1:0]         quad;
        longint             x;
        longint             y;
        longint             z;
        longint             nx;
        int                 k;
        q    = ((phase + 32'h20000000) >> 30) & 32'd3;
        d    = phase - (q << 30);
        zs   = d;
        z    = zs;
        x    = 652032874;
        y    = 0;
        quad = q[1:0];
        for (int i = 0; i < STEPS; i++)
        begin
            k = i & 31;
            if (z >= 0)
            begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - atan_step(k);
            end
            else
            begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + atan_step(k);
            end
            x = nx;
        end
        case (quad)
            QUAD_0:  begin c = x;  s = y;  end
            QUAD_1:  begin c = -y; s = x;  end
            QUAD_2:  begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    // Exact products, round half up at bit 30, saturate
    function automatic void turn_pair(input logic signed [31:0] a, input logic signed [31:0] b,
                                      input longint c, input longint s,
                                      output logic signed [31:0] ra,
                                      output logic signed [31:0] rb);
        longint aa;
        longint bb;
        aa = a;
        bb = b;
        ra = clamp32((aa * c - bb * s + HALF_LSB) >>> 30);
        rb = clamp32((aa * s + bb * c + HALF_LSB) >>> 30);
    endfunction

    function automatic result_t rotate_point(input point_t p);
        result_t r;
        longint  c;
        longint  s;
        r.rx = p.px;
        r.ry = p.py;
        r.rz = p.pz;
        if (p.axis == AXIS_NONE)
            return r;
        cordic_sincos(phase_of_angle(p.kind, p.turn), c, s);
        case (p.axis)
            AXIS_X:  turn_pair(p.py, p.pz, c, s, r.ry, r.rz);
            AXIS_Y:  turn_pair(p.pz, p.px, c, s, r.rz, r.rx);
            default: turn_pair(p.px, p.py, c, s, r.rx, r.ry);
        endcase
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic void add_row(input logic kind, input logic signed [31:0] px,
                                    input logic signed [31:0] py, input logic signed [31:0] pz,
                                    input logic [1:0] axis, input logic signed [31:0] turn,
                                    input bit has, input logic signed [31:0] rx = 0,
                                    input logic signed [31:0] ry = 0,
                                    input logic signed [31:0] rz = 0);
        row_t w;
        w.pt.kind = kind;
        w.pt.px   = px;
        w.pt.py   = py;
        w.pt.pz   = pz;
        w.pt.axis = axis;
        w.pt.turn = turn;
        w.has_exp = has;
        w.exp.rx  = rx;
        w.exp.ry  = ry;
        w.exp.rz  = rz;
        dir_rows.push_back(w);
    endfunction

    function automatic logic signed [31:0] coord_pick();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3:       return $urandom_range(0, 1) ? MAXV : MINV;
            4:       return $urandom_range(0, 1) ? MAXV - $urandom_range(0, 255)
                                                 : MINV + $urandom_range(0, 255);
            default: return $urandom_range(0, 32'h1FFFFF) - 32'h100000;
        endcase
    endfunction

    function automatic logic signed [31:0] angle_pick(input logic kind);
        int step;
        case ($urandom_range(0, 7))
            0, 1: return $urandom();
            2:
            begin
                // multiples of an eighth turn, a few LSBs off the quadrant edges
                step = (kind == KIND_DEG) ? 45 * DEG : 51472;
                return (int'($urandom_range(0, 16)) - 8) * step + int'($urandom_range(0, 4)) - 2;
            end
            default:
                if (kind == KIND_DEG)
                    return $urandom_range(0, 1440 * DEG) - 720 * DEG;
                else
                    return $urandom_range(0, 16 * DEG) - 8 * DEG;
        endcase
    endfunction

    function automatic point_t point_pick();
        point_t p;
        p.kind = 1'($urandom_range(0, 1));
        p.px   = coord_pick();
        p.py   = coord_pick();
        p.pz   = coord_pick();
        p.axis = ($urandom_range(0, 15) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
        p.turn = angle_pick(p.kind);
        return p;
    endfunction

    // Offer one point and hold it until the transfer
    task automatic push_point(input point_t p, input bit has, input result_t e);
        point_valid <= 1'b1;
        point       <= p;
        typed_has   <= has;
        typed_res   <= e;
        @(posedge clk);
        while (!point_ready)
            @(posedge clk);
        sent_n++;
    endtask

    task automatic pause_sender(input int n);
        point_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d (%h), actual %0d (%h)", name, want, want, got, got);
            fails++;
        end
    endtask

    // ---------------- result side ----------------

    // Receiver backpressure in bursts of random length
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (rst_n && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= $urandom_range(0, 9);
        end
        else
        begin
            result_ready <= rst_n;
        end
    end

    // Check result transfers, then record the prediction for an accepted point
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (rotated_q.size() == 0)
                begin
                    $error("result with nothing expected: rx %0d ry %0d rz %0d",
                           result.rx, result.ry, result.rz);
                    fails++;
                end
                else
                begin
                    want = rotated_q.pop_front();
                    check_field("rx", want.rx, result.rx);
                    check_field("ry", want.ry, result.ry);
                    check_field("rz", want.rz, result.rz);
                    checked_n++;
                end
            end
            if (point_valid && point_ready)
                rotated_q.push_back(typed_has ? typed_res : rotate_point(point));
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CYCLE_CAP)
        begin
            $display("axis_point_rotator_tb NOT OK");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin : driver
        int      gap_odds;
        int      dir_n;
        point_t  p;
        result_t none;
        none     = '0;
        gap_odds = 4;

        // Pass-through for axis code three, both units, extreme angles
        add_row(KIND_RAD, MAXV, MINV, 32'sh12345678, AXIS_NONE, MINV, 1'b1,
                MAXV, MINV, 32'sh12345678);
        add_row(KIND_DEG, MINV, MAXV, -1, AXIS_NONE, MAXV, 1'b1, MINV, MAXV, -1);
        add_row(KIND_RAD, 0, 0, 0, AXIS_NONE, 0, 1'b1, 0, 0, 0);
        // Origin stays at the origin
        add_row(KIND_DEG, 0, 0, 0, AXIS_X, 90 * DEG, 1'b1, 0, 0, 0);
        // Quadrants in degrees, each axis
        add_row(KIND_DEG, DEG, 0, 0, AXIS_Z, 0, 1'b0);
        add_row(KIND_DEG, DEG, 0, 0, AXIS_Z, 90 * DEG, 1'b0);
        add_row(KIND_DEG, 7 * DEG, DEG, 2 * DEG, AXIS_X, 180 * DEG, 1'b0);
        add_row(KIND_DEG, 3 * DEG, 4 * DEG, 5 * DEG, AXIS_Y, 270 * DEG, 1'b0);
        add_row(KIND_DEG, 3 * DEG, -4 * DEG, 5 * DEG, AXIS_Z, 360 * DEG, 1'b0);
        add_row(KIND_DEG, -3 * DEG, 4 * DEG, -5 * DEG, AXIS_X, -90 * DEG, 1'b0);
        // Eighth-turn edges of the residual phase
        add_row(KIND_DEG, 10 * DEG, 20 * DEG, 30 * DEG, AXIS_Z, 45 * DEG, 1'b0);
        add_row(KIND_DEG, 10 * DEG, 20 * DEG, 30 * DEG, AXIS_Y, 135 * DEG, 1'b0);
        add_row(KIND_DEG, 10 * DEG, 20 * DEG, 30 * DEG, AXIS_X, -45 * DEG, 1'b0);
        // Extreme angles in degrees and radians
        add_row(KIND_DEG, DEG, 2 * DEG, 3 * DEG, AXIS_Z, MAXV, 1'b0);
        add_row(KIND_DEG, DEG, 2 * DEG, 3 * DEG, AXIS_X, MINV, 1'b0);
        add_row(KIND_RAD, DEG, 2 * DEG, 3 * DEG, AXIS_Y, 205887, 1'b0);
        add_row(KIND_RAD, DEG, 2 * DEG, 3 * DEG, AXIS_Z, -102944, 1'b0);
        add_row(KIND_RAD, DEG, 2 * DEG, 3 * DEG, AXIS_X, MAXV, 1'b0);
        add_row(KIND_RAD, DEG, 2 * DEG, 3 * DEG, AXIS_Y, MINV, 1'b0);
        // Extreme coordinates, results past the range saturate
        add_row(KIND_DEG, MAXV, MINV, 0, AXIS_Z, 45 * DEG, 1'b0);
        add_row(KIND_DEG, 5, MINV, MINV, AXIS_X, 45 * DEG, 1'b0);
        add_row(KIND_DEG, MAXV, 0, MINV, AXIS_Y, 135 * DEG, 1'b0);
        add_row(KIND_DEG, MINV, MINV, MAXV, AXIS_Z, 180 * DEG, 1'b0);
        add_row(KIND_RAD, MAXV, MAXV, MAXV, AXIS_Z, 205887, 1'b0);
        dir_n = dir_rows.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
        begin
            if ($urandom_range(0, gap_odds - 1) == 0)
                pause_sender($urandom_range(1, 10));
            push_point(dir_rows[i].pt, dir_rows[i].has_exp, dir_rows[i].exp);
        end

        // Random points, idling rates change every 64 items until the calm tail
        for (int i = 0; i < RAND_N; i++)
        begin
            if (i % 64 == 0 && i < RAND_N - CALM_N)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 2;
                    default: gap_odds = 8;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_odds <= 0;
                    1:       stall_odds <= 2;
                    default: stall_odds <= 8;
                endcase
            end
            if (i == RAND_N - CALM_N)
            begin
                gap_odds   = 0;
                stall_odds <= 0;
            end
            // Let the pipeline empty once with the sender held off
            if (i == RAND_N / 2)
            begin
                point_valid <= 1'b0;
                @(posedge clk);
                while (rotated_q.size() != 0)
                    @(posedge clk);
            end
            else if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
            begin
                pause_sender($urandom_range(1, 10));
            end
            p = point_pick();
            push_point(p, 1'b0, none);
        end

        // Drain, then watch for stray results
        point_valid <= 1'b0;
        while (rotated_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Sent %0d points (%0d from the directed table), checked %0d results,",
                 sent_n, dir_n, checked_n);
        $display("over all axis codes, both angle units and saturating coordinates.");
        if (fails == 0)
            $display("axis_point_rotator_tb OK");
        else
            $display("axis_point_rotator_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/apr_pkg.sv
hdl/apr_phase.sv
hdl/apr_cordic_cell.sv
hdl/apr_rotate.sv
hdl/axis_point_rotator.sv
dv/axis_point_rotator_tb.sv
